FILE: src/tbe_pkg.sv
package tbe_pkg;

	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_N     = 8'h4E;
	localparam logic [7:0] CH_QUOTE = 8'h27;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_PAREN = 8'h28;
	localparam logic [7:0] CH_EIGHT = 8'h38;
	localparam logic [7:0] CH_ONE   = 8'h31;

	localparam logic [8:0] PASS_LIMIT_RST = 9'd127;

	// bit escape: 9 groups of 4 bytes
	localparam logic [5:0] ESC_LAST = 6'd35;

	// prefix bytes emitted before the body of a command
	localparam logic [1:0] PRE_NONE = 2'd0;
	localparam logic [1:0] PRE_BSL  = 2'd1;
	localparam logic [1:0] PRE_BSLN = 2'd2;

	typedef struct packed {
		logic [1:0] pre;
		logic       is_bits;
		logic [7:0] val;
	} cmd_t;

endpackage

FILE: src/text_byte_escape_encoder.sv
// channel  | handshake          | payload
// in       | in_valid/in_stall  | in_byte
// out      | out_valid/out_stall| out_byte, last_of_run
// cfg      | cfg_we             | cfg_data (pass_limit)
//
// Plain bytes go through at one per cycle while out_stall is low; each byte is written
// into the command queue and then loaded into the output register before it transfers.
// A bit escape emits 36 output bytes (38 with a broken \N prefix), produced by
// the byte sequencer; the front keeps parsing until the command queue is full.
// Bytes that only advance the parser are consumed and emit nothing.
// Reset clears parser, queue and output valid; pass_limit returns to 127.
module text_byte_escape_encoder
	import tbe_pkg::*;
#(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       last_of_run,
	input  logic       cfg_we,
	input  logic [8:0] cfg_data
);

	logic q_full;
	logic push;
	logic pop;
	logic head_valid;
	cmd_t push_cmd;
	cmd_t head_cmd;

	assign in_stall = q_full;

	tbe_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_byte  (in_byte),
		.q_full   (q_full),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.push     (push),
		.cmd      (push_cmd)
	);

	tbe_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.pop        (pop),
		.full       (q_full),
		.head_valid (head_valid),
		.head_cmd   (head_cmd)
	);

	tbe_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_valid  (head_valid),
		.head_cmd    (head_cmd),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_byte    (out_byte),
		.last_of_run (last_of_run)
	);

endmodule

FILE: src/tbe_front.sv
module tbe_front
	import tbe_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [7:0] in_byte,
	input  logic       q_full,
	input  logic       cfg_we,
	input  logic [8:0] cfg_data,
	output logic       push,
	output cmd_t       cmd
);

	localparam logic [2:0] ST_TEXT   = 3'd0;
	localparam logic [2:0] ST_BSL    = 3'd1;
	localparam logic [2:0] ST_BSLN   = 3'd2;
	localparam logic [2:0] ST_DIGITS = 3'd3;
	localparam logic [2:0] ST_SKIP   = 3'd4;

	logic [2:0] state_q, state_d;
	logic [7:0] dec_q, dec_d;
	logic [8:0] pass_limit_q;
	logic       accept;
	logic       emit;
	logic       plain_bits;
	logic       is_digit;
	logic [7:0] digit;

	assign accept     = in_valid && !q_full;
	assign plain_bits = ({1'b0, in_byte} >= pass_limit_q);
	assign is_digit   = (in_byte >= CH_ZERO) && (in_byte <= CH_NINE);
	assign digit      = in_byte - CH_ZERO;

	always_comb begin
		state_d     = state_q;
		dec_d       = dec_q;
		emit        = 1'b0;
		cmd.pre     = PRE_NONE;
		cmd.is_bits = plain_bits;
		cmd.val     = in_byte;
		case (state_q)
			ST_DIGITS, ST_SKIP: begin
				if (in_byte == CH_QUOTE) begin
					state_d     = ST_TEXT;
					emit        = 1'b1;
					cmd.is_bits = 1'b1;
					cmd.val     = dec_q;
				end else if (state_q == ST_DIGITS) begin
					if (!is_digit)
						state_d = ST_SKIP;
					else
						dec_d = {dec_q[4:0], 3'b000} + {dec_q[6:0], 1'b0} + digit;
				end
			end
			ST_BSLN: begin
				if (in_byte == CH_QUOTE) begin
					state_d = ST_DIGITS;
					dec_d   = 8'd0;
				end else begin
					state_d = ST_TEXT;
					emit    = 1'b1;
					cmd.pre = PRE_BSLN;
				end
			end
			ST_BSL: begin
				if (in_byte == CH_N) begin
					state_d = ST_BSLN;
				end else begin
					state_d = ST_TEXT;
					emit    = 1'b1;
					cmd.pre = PRE_BSL;
				end
			end
			default: begin
				if (in_byte == CH_BSL) begin
					state_d = ST_BSL;
				end else begin
					state_d = ST_TEXT;
					emit    = 1'b1;
				end
			end
		endcase
	end

	assign push = accept && emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_TEXT;
			dec_q        <= 8'd0;
			pass_limit_q <= PASS_LIMIT_RST;
		end else begin
			if (cfg_we)
				pass_limit_q <= cfg_data;
			if (accept) begin
				state_q <= state_d;
				dec_q   <= dec_d;
			end
		end
	end

endmodule

FILE: src/tbe_queue.sv
module tbe_queue
	import tbe_pkg::*;
#(
	parameter int DEPTH = 2
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	input  logic pop,
	output logic full,
	output logic head_valid,
	output cmd_t head_cmd
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	cmd_t          mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full       = (count_q == FULL_CNT);
	assign head_valid = (count_q != '0);
	assign head_cmd   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

FILE: src/tbe_back.sv
module tbe_back
	import tbe_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       head_valid,
	input  cmd_t       head_cmd,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       last_of_run
);

	logic [1:0] pstep_q;
	logic [5:0] k_q;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       out_last_q;
	logic       load;
	logic       in_pre;
	logic [7:0] cur_byte;
	logic       cur_last;
	logic [3:0] grp;
	logic [2:0] bit_sel;

	assign in_pre  = (pstep_q < head_cmd.pre);
	assign grp     = k_q[5:2];
	assign bit_sel = 3'(4'd8 - grp);

	always_comb begin
		cur_byte = head_cmd.val;
		cur_last = 1'b1;
		if (in_pre) begin
			cur_byte = (pstep_q == 2'd0) ? CH_BSL : CH_N;
			cur_last = 1'b0;
		end else if (head_cmd.is_bits) begin
			cur_last = (k_q == ESC_LAST);
			case (k_q[1:0])
				2'd0:    cur_byte = CH_BSL;
				2'd1:    cur_byte = CH_PAREN;
				2'd2:    cur_byte = CH_EIGHT;
				default: begin
					if (grp == 4'd0)
						cur_byte = CH_EIGHT;
					else
						cur_byte = head_cmd.val[bit_sel] ? CH_ONE : CH_ZERO;
				end
			endcase
		end
	end

	assign load = head_valid && (!out_valid_q || !out_stall);
	assign pop  = load && cur_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pstep_q     <= 2'd0;
			k_q         <= 6'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				if (cur_last) begin
					pstep_q <= 2'd0;
					k_q     <= 6'd0;
				end else if (in_pre) begin
					pstep_q <= pstep_q + 2'd1;
				end else begin
					k_q <= k_q + 6'd1;
				end
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q <= cur_byte;
			out_last_q <= cur_last;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_byte    = out_byte_q;
	assign last_of_run = out_last_q;

endmodule

FILE: tb/text_byte_escape_encoder_tb.sv
`timescale 1ns / 1ps

import tbe_pkg::*;

typedef enum logic [2:0] {
	PS_TEXT,
	PS_BSL,
	PS_BSLN,
	PS_DIGITS,
	PS_SKIP
} parse_state_t;

typedef struct packed {
	logic [7:0] ch;
	logic       last_of_run;
} text_out_t;

class escape_scoreboard;
	text_out_t    expected_q[$];
	parse_state_t pstate;
	logic [8:0]   limit;
	logic [7:0]   dec_val;
	int           errors;

	function new();
		pstate  = PS_TEXT;
		limit   = PASS_LIMIT_RST;
		dec_val = 8'd0;
		errors  = 0;
	endfunction

	function void set_limit(logic [8:0] v);
		limit = v;
	endfunction

	function int pending();
		return expected_q.size();
	endfunction

	function void push_byte(logic [7:0] c);
		expected_q.push_back('{ch: c, last_of_run: 1'b0});
	endfunction

	function void push_group(logic [7:0] tail);
		push_byte(CH_BSL);
		push_byte(CH_PAREN);
		push_byte(CH_EIGHT);
		push_byte(tail);
	endfunction

	function void push_bit_escape(logic [7:0] v);
		push_group(CH_EIGHT);
		for (int i = 7; i >= 0; i--)
			push_group(v[i] ? CH_ONE : CH_ZERO);
	endfunction

	function void push_plain(logic [7:0] b);
		if ({1'b0, b} < limit)
			push_byte(b);
		else
			push_bit_escape(b);
	endfunction

	// one accepted input byte: advance the parser and queue the bytes it yields
	function void note_input(logic [7:0] b);
		int base;
		base = expected_q.size();
		case (pstate)
			PS_DIGITS, PS_SKIP: begin
				if (b == CH_QUOTE) begin
					pstate = PS_TEXT;
					push_bit_escape(dec_val);
				end else if (pstate == PS_DIGITS) begin
					if (b < CH_ZERO || b > CH_NINE)
						pstate = PS_SKIP;
					else
						dec_val = dec_val * 8'd10 + (b - CH_ZERO);
				end
			end
			PS_BSLN: begin
				if (b == CH_QUOTE) begin
					pstate  = PS_DIGITS;
					dec_val = 8'd0;
				end else begin
					pstate = PS_TEXT;
					push_byte(CH_BSL);
					push_byte(CH_N);
					push_plain(b);
				end
			end
			PS_BSL: begin
				if (b == CH_N) begin
					pstate = PS_BSLN;
				end else begin
					pstate = PS_TEXT;
					push_byte(CH_BSL);
					push_plain(b);
				end
			end
			default: begin
				if (b == CH_BSL) begin
					pstate = PS_BSL;
				end else begin
					pstate = PS_TEXT;
					push_plain(b);
				end
			end
		endcase
		if (expected_q.size() > base)
			expected_q[expected_q.size() - 1].last_of_run = 1'b1;
	endfunction

	task report(string msg);
		$display("mismatch: %s", msg);
		errors++;
	endtask

	task check_result(logic [7:0] ch, logic lor);
		text_out_t e;
		if (expected_q.size() == 0) begin
			report($sformatf("unexpected output byte %h last %b", ch, lor));
		end else begin
			e = expected_q.pop_front();
			if (e.ch !== ch)
				report($sformatf("out_byte %h, expected %h", ch, e.ch));
			if (e.last_of_run !== lor)
				report($sformatf("last_of_run %b, expected %b (byte %h)", lor,
					e.last_of_run, e.ch));
		end
	endtask
endclass

module text_byte_escape_encoder_tb;
	localparam int HOLD_CYCLES   = 200;
	localparam int SETTLE_CYCLES = 8;

	logic       clk;
	logic       arst_n    = 1'b0;
	logic       in_valid  = 1'b0;
	logic       in_stall;
	logic [7:0] in_byte   = 8'd0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] out_byte;
	logic       last_of_run;
	logic       cfg_we    = 1'b0;
	logic [8:0] cfg_data  = 9'd0;

	logic       hold_go    = 1'b0;
	logic       idle_en    = 1'b1;
	int         bytes_sent = 0;

	escape_scoreboard sb = new();

	logic [7:0] directed_q[$] = '{
		8'h00, 8'h7E, 8'h7F, 8'hFF,
		// value wraps past 255
		CH_BSL, CH_N, CH_QUOTE, 8'h32, 8'h39, 8'h30, CH_QUOTE,
		// empty quotes
		CH_BSL, CH_N, CH_QUOTE, CH_QUOTE,
		// second backslash is plain text
		CH_BSL, CH_BSL, CH_N,
		// \N broken by a high byte
		CH_BSL, CH_N, 8'hFF,
		// non-digit stops the digits, rest dropped
		CH_BSL, CH_N, CH_QUOTE, 8'h37, 8'h3A, 8'h39, CH_QUOTE
	};

	text_byte_escape_encoder u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_byte     (in_byte),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_byte    (out_byte),
		.last_of_run (last_of_run),
		.cfg_we      (cfg_we),
		.cfg_data    (cfg_data)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	initial begin
		#2_000_000;
		$display("text_byte_escape_encoder_tb failed");
		$finish;
	end

	// handshakes are sampled mid-cycle, where every input and output is settled
	always @(negedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(out_byte, last_of_run);
	end

	initial begin
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (hold_go) begin
				hold_go = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES - 1) @(posedge clk);
			end else begin
				out_stall <= idle_en && ($urandom_range(99) < 9);
			end
		end
	end

	task automatic send_byte(input logic [7:0] b);
		logic ok;
		while (idle_en && $urandom_range(99) < 9) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte  <= b;
		ok = 1'b0;
		while (!ok) begin
			@(negedge clk);
			ok = !in_stall;
			if (ok)
				sb.note_input(b);
			@(posedge clk);
		end
		bytes_sent++;
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		// parse-only bytes may still be in flight
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_limit(input logic [8:0] v);
		cfg_we   <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_limit(v);
	endtask

	task automatic send_random_chunk();
		int         kind;
		logic [7:0] c;
		kind = $urandom_range(99);
		if (kind < 30) begin
			repeat ($urandom_range(6, 1)) begin
				c = 8'($urandom_range(8'h7E, 8'h20));
				send_byte(c == CH_BSL ? CH_N : c);
			end
		end else if (kind < 45) begin
			send_byte(8'($urandom_range(255)));
		end else if (kind < 75) begin
			send_byte(CH_BSL);
			send_byte(CH_N);
			send_byte(CH_QUOTE);
			repeat ($urandom_range(4)) send_byte(CH_ZERO + 8'($urandom_range(9)));
			send_byte(CH_QUOTE);
		end else if (kind < 88) begin
			send_byte(CH_BSL);
			send_byte(CH_N);
			send_byte(CH_QUOTE);
			repeat ($urandom_range(2)) send_byte(CH_ZERO + 8'($urandom_range(9)));
			repeat ($urandom_range(3, 1)) begin
				c = 8'($urandom_range(255));
				if (c == CH_QUOTE || (c >= CH_ZERO && c <= CH_NINE))
					c = 8'h7A;
				send_byte(c);
			end
			send_byte(CH_QUOTE);
		end else begin
			// prefix left unfinished by the following byte
			send_byte(CH_BSL);
			if ($urandom_range(1))
				send_byte(CH_N);
			c = 8'($urandom_range(255));
			send_byte((c == CH_N || c == CH_QUOTE) ? 8'hE9 : c);
		end
	endtask

	task automatic run_phase(input logic [8:0] lim, input int n, input bit hold_off,
		input bit mid_pause);
		int target;
		int half;
		drain_results();
		write_limit(lim);
		if (hold_off)
			hold_go = 1'b1;
		target = bytes_sent + n;
		half   = bytes_sent + n / 2;
		while (bytes_sent < target) begin
			send_random_chunk();
			if (mid_pause && bytes_sent >= half) begin
				mid_pause = 1'b0;
				drain_results();
			end
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed_q[i])
			send_byte(directed_q[i]);
		run_phase(9'd0, 25, 1'b0, 1'b0);
		idle_en = 1'b0;
		run_phase(9'd256, 30, 1'b0, 1'b0);
		idle_en = 1'b1;
		run_phase(9'd1, 25, 1'b1, 1'b0);
		run_phase(9'd255, 25, 1'b0, 1'b1);
		run_phase(9'd128, 25, 1'b0, 1'b0);
		run_phase(9'($urandom_range(256)), 15, 1'b0, 1'b0);
		run_phase(9'($urandom_range(256)), 15, 1'b0, 1'b0);
		drain_results();
		if (sb.errors == 0)
			$display("text_byte_escape_encoder_tb passed");
		else
			$display("text_byte_escape_encoder_tb failed");
		$finish;
	end
endmodule

FILE: filelist.f
src/tbe_pkg.sv
src/tbe_front.sv
src/tbe_queue.sv
src/tbe_back.sv
src/text_byte_escape_encoder.sv
tb/text_byte_escape_encoder_tb.sv
